### rtl/scfla_pkg.sv
// Shared constants, codes and helper functions for the size-class free-list allocator.
// Used by the allocator top level; depends on nothing else.
`default_nettype none

package scfla_pkg;

    localparam int NUM_PAGES    = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int NUM_CLASSES  = 7;
    localparam int HEADER_BYTES = 8;

    localparam int MIN_CELL  = 32;
    localparam int MIN_SHIFT = 5;

    localparam int NUM_GRANULES    = (NUM_PAGES * PAGE_BYTES) / MIN_CELL;
    localparam int GRAN_W          = $clog2(NUM_GRANULES);
    localparam int HEAD_W          = GRAN_W + 1;
    localparam int WORD_W          = HEAD_W;
    localparam int PAGE_GRANULES   = PAGE_BYTES / MIN_CELL;
    localparam int PAGE_SHIFT      = $clog2(PAGE_GRANULES);
    localparam int CNT_W           = PAGE_SHIFT + 1;
    localparam int PAGE_W          = $clog2(NUM_PAGES + 1);
    localparam int CLS_W           = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MAX_CLASS_BYTES = MIN_CELL << (NUM_CLASSES - 1);

    localparam int REQ_W   = 16;
    localparam int ADDR_W  = 18;
    localparam int BYTES_W = 12;
    localparam int TOTAL_W = REQ_W + 1;
    localparam int CFG_W   = 4;
    localparam int CELLG_W = ADDR_W - MIN_SHIFT;

    localparam logic [CFG_W-1:0] REFILL_RESET = CFG_W'(4);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OOM       = 2'd1,
        STATUS_TOO_LARGE = 2'd2
    } status_t;

    // Smallest class whose cell holds the given byte count, clamped to the top class.
    function automatic logic [CLS_W-1:0] class_of(input logic [TOTAL_W-1:0] total);
        logic [CLS_W-1:0] c;
        c = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
            if (total <= TOTAL_W'(MIN_CELL << i))
            begin
                c = CLS_W'(i);
            end
        end
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        return WORD_W'(MIN_CELL) << c;
    endfunction

endpackage

`default_nettype wire

### rtl/scfla_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// Stand-alone; no package dependencies.
`default_nettype none

module scfla_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/size_class_free_list_allocator_unit.sv
// Size-class free-list allocator: seven power-of-two classes over a pool of fixed pages.
// Depends on scfla_pkg and the generic RAM scfla_ram (one header word per 32-byte granule).
//
// Usage:
//   Requests enter on in_valid/in_stall with op, request_bytes and block_address.
//   Every request yields exactly one result on out_valid/out_stall carrying
//   granted_address, granted_bytes and status. The refill_pages register is
//   written on cfg_valid/cfg_ready while no request is in flight.
//   One request is worked on at a time. A list hit (allocate) or a free passes
//   through accept, header read and write-back on its way to the result
//   register. An allocate that finds its list empty carves pages first, one
//   cell header at a time (PAGE_BYTES / cell size cells per page) with a
//   page step between pages, and then pops a cell. The first request after
//   reset carves one page per class first, 254 cells in all.
//   The header RAM sees at most one access per cycle.
//   Reset empties all class lists, rewinds the page pool and sets
//   refill_pages to 4; the header RAM is not cleared.
//   While the receiver stalls, the result stays in the output register and
//   the next request is still accepted; it then waits with its own result
//   until the output register frees up.
`default_nettype none

module size_class_free_list_allocator_unit
    import scfla_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               op,
    input  wire logic [REQ_W-1:0]   request_bytes,
    input  wire logic [ADDR_W-1:0]  block_address,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [ADDR_W-1:0]  granted_address,
    output logic      [BYTES_W-1:0] granted_bytes,
    output logic      [1:0]         status,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_PLAN   = 8'b0000_0100,
        S_CARVE  = 8'b0000_1000,
        S_POP    = 8'b0001_0000,
        S_PWAIT  = 8'b0010_0000,
        S_FREAD  = 8'b0100_0000,
        S_HOLD   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic                op_reg, op_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [PAGE_SHIFT-1:0] k_reg, k_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [CFG_W-1:0]    pages_left_reg, pages_left_next;
    logic [GRAN_W-1:0]   gran_reg, gran_next;
    logic                carve_done_reg, carve_done_next;
    logic [CFG_W-1:0]    refill_reg, refill_next;
    logic [HEAD_W-1:0]   heads_reg [NUM_CLASSES];
    logic [HEAD_W-1:0]   heads_next [NUM_CLASSES];
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [BYTES_W-1:0]  res_bytes_reg, res_bytes_next;
    status_t             res_status_reg, res_status_next;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [BYTES_W-1:0]  out_bytes_reg;
    status_t             out_status_reg;

    logic                ram_wr_en, ram_rd_en;
    logic [GRAN_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [WORD_W-1:0]   ram_wr_data, ram_rd_data;

    logic                in_acc, out_free, out_load;
    logic                fin_valid;
    logic [ADDR_W-1:0]   fin_addr;
    logic [BYTES_W-1:0]  fin_bytes;
    status_t             fin_status;

    logic [CNT_W-1:0]    cells_cur;
    logic                page_ok, cell_last;
    logic [GRAN_W-1:0]   page_base, carve_gran;
    logic [PAGE_SHIFT-1:0] k_sh;
    logic [TOTAL_W-1:0]  alloc_total;
    logic [CLS_W-1:0]    alloc_cls, free_cls;
    logic [HEAD_W-1:0]   dec_head, pop_head;
    logic [ADDR_W-1:0]   free_cell;
    logic [CELLG_W-1:0]  free_gran;

    scfla_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_GRANULES)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign granted_bytes   = out_bytes_reg;
    assign status          = out_status_reg;

    // Carve geometry for the current page and class.
    assign cells_cur  = CNT_W'(PAGE_GRANULES) >> cls_reg;
    assign page_ok    = (int'(page_reg) < NUM_PAGES);
    assign cell_last  = (({1'b0, k_reg} + CNT_W'(1)) == cells_cur);
    assign page_base  = GRAN_W'(page_reg) << PAGE_SHIFT;
    assign k_sh       = k_reg << cls_reg;
    assign carve_gran = page_base | GRAN_W'(k_sh);

    assign alloc_total = TOTAL_W'(req_reg) + TOTAL_W'(HEADER_BYTES);
    assign alloc_cls   = class_of(alloc_total);
    assign dec_head    = heads_reg[alloc_cls];
    assign pop_head    = heads_reg[cls_reg];
    assign free_cell   = addr_reg - ADDR_W'(HEADER_BYTES);
    assign free_gran   = free_cell[ADDR_W-1:MIN_SHIFT];
    assign free_cls    = class_of(TOTAL_W'(ram_rd_data));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        cls_next        = cls_reg;
        k_next          = k_reg;
        page_next       = page_reg;
        pages_left_next = pages_left_reg;
        gran_next       = gran_reg;
        carve_done_next = carve_done_reg;
        refill_next     = refill_reg;
        heads_next      = heads_reg;
        res_addr_next   = res_addr_reg;
        res_bytes_next  = res_bytes_reg;
        res_status_next = res_status_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = gran_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = gran_reg;

        fin_valid  = 1'b0;
        fin_addr   = '0;
        fin_bytes  = '0;
        fin_status = STATUS_OK;
        out_load   = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            refill_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next   = op;
                    req_next  = request_bytes;
                    addr_next = block_address;
                    if (carve_done_reg)
                    begin
                        state_next = S_DECODE;
                    end
                    else
                    begin
                        cls_next   = '0;
                        state_next = S_PLAN;
                    end
                end
            end

            S_DECODE:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (int'(alloc_total) > MAX_CLASS_BYTES)
                    begin
                        fin_valid  = 1'b1;
                        fin_status = STATUS_TOO_LARGE;
                    end
                    else
                    begin
                        cls_next = alloc_cls;
                        if (dec_head == '0)
                        begin
                            pages_left_next = refill_reg;
                            state_next      = S_PLAN;
                        end
                        else if (int'(dec_head) > NUM_GRANULES)
                        begin
                            // A link outside the pool empties the list and the allocate fails out of memory.
                            heads_next[alloc_cls] = '0;
                            fin_valid             = 1'b1;
                            fin_status            = STATUS_OOM;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = GRAN_W'(dec_head - HEAD_W'(1));
                            gran_next   = GRAN_W'(dec_head - HEAD_W'(1));
                            state_next  = S_PWAIT;
                        end
                    end
                end
                else
                begin
                    if (int'(free_gran) >= NUM_GRANULES)
                    begin
                        fin_valid = 1'b1;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = GRAN_W'(free_gran);
                        gran_next   = GRAN_W'(free_gran);
                        state_next  = S_FREAD;
                    end
                end
            end

            S_PLAN:
            begin
                if (!carve_done_reg)
                begin
                    if (page_ok && (cells_cur != '0))
                    begin
                        k_next     = '0;
                        state_next = S_CARVE;
                    end
                    else if (cls_reg == CLS_W'(NUM_CLASSES - 1))
                    begin
                        carve_done_next = 1'b1;
                        state_next      = S_DECODE;
                    end
                    else
                    begin
                        cls_next = cls_reg + CLS_W'(1);
                    end
                end
                else if ((pages_left_reg != '0) && page_ok)
                begin
                    if (cells_cur != '0)
                    begin
                        k_next     = '0;
                        state_next = S_CARVE;
                    end
                    else
                    begin
                        pages_left_next = pages_left_reg - CFG_W'(1);
                    end
                end
                else
                begin
                    state_next = S_POP;
                end
            end

            S_CARVE:
            begin
                // One cell header per cycle; the last cell links to the old list head.
                ram_wr_en   = 1'b1;
                ram_wr_addr = carve_gran;
                if (cell_last)
                begin
                    ram_wr_data       = heads_reg[cls_reg];
                    heads_next[cls_reg] = HEAD_W'(page_base) + HEAD_W'(1);
                    page_next         = page_reg + PAGE_W'(1);
                    state_next        = S_PLAN;
                    if (!carve_done_reg)
                    begin
                        if (cls_reg == CLS_W'(NUM_CLASSES - 1))
                        begin
                            carve_done_next = 1'b1;
                            state_next      = S_DECODE;
                        end
                        else
                        begin
                            cls_next = cls_reg + CLS_W'(1);
                        end
                    end
                    else
                    begin
                        pages_left_next = pages_left_reg - CFG_W'(1);
                    end
                end
                else
                begin
                    ram_wr_data = HEAD_W'(carve_gran) + (HEAD_W'(1) << cls_reg) + HEAD_W'(1);
                    k_next      = k_reg + PAGE_SHIFT'(1);
                end
            end

            S_POP:
            begin
                if (pop_head == '0)
                begin
                    fin_valid  = 1'b1;
                    fin_status = STATUS_OOM;
                end
                else if (int'(pop_head) > NUM_GRANULES)
                begin
                    heads_next[cls_reg] = '0;
                    fin_valid           = 1'b1;
                    fin_status          = STATUS_OOM;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = GRAN_W'(pop_head - HEAD_W'(1));
                    gran_next   = GRAN_W'(pop_head - HEAD_W'(1));
                    state_next  = S_PWAIT;
                end
            end

            S_PWAIT:
            begin
                heads_next[cls_reg] = ram_rd_data;
                ram_wr_en           = 1'b1;
                ram_wr_addr         = gran_reg;
                ram_wr_data         = class_bytes(cls_reg);
                fin_valid           = 1'b1;
                fin_addr            = (ADDR_W'(gran_reg) << MIN_SHIFT) + ADDR_W'(HEADER_BYTES);
                fin_bytes           = BYTES_W'(class_bytes(cls_reg));
            end

            S_FREAD:
            begin
                // A header above the largest class belongs to no list: drop the free.
                if (int'(ram_rd_data) <= MAX_CLASS_BYTES)
                begin
                    ram_wr_en            = 1'b1;
                    ram_wr_addr          = gran_reg;
                    ram_wr_data          = heads_reg[free_cls];
                    heads_next[free_cls] = HEAD_W'(gran_reg) + HEAD_W'(1);
                end
                fin_valid = 1'b1;
            end

            S_HOLD:
            begin
                fin_valid  = 1'b1;
                fin_addr   = res_addr_reg;
                fin_bytes  = res_bytes_reg;
                fin_status = res_status_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin_valid)
        begin
            if (out_free)
            begin
                out_load   = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                res_addr_next   = fin_addr;
                res_bytes_next  = fin_bytes;
                res_status_next = fin_status;
                state_next      = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cls_reg        <= '0;
            k_reg          <= '0;
            page_reg       <= '0;
            pages_left_reg <= '0;
            carve_done_reg <= 1'b0;
            refill_reg     <= REFILL_RESET;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cls_reg        <= cls_next;
            k_reg          <= k_next;
            page_reg       <= page_next;
            pages_left_reg <= pages_left_next;
            carve_done_reg <= carve_done_next;
            refill_reg     <= refill_next;
            heads_reg      <= heads_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        gran_reg       <= gran_next;
        res_addr_reg   <= res_addr_next;
        res_bytes_reg  <= res_bytes_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_addr_reg   <= fin_addr;
            out_bytes_reg  <= fin_bytes;
            out_status_reg <= fin_status;
        end
    end

    // The header RAM is never read and written in the same cycle.
    a_ram_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> !ram_wr_en)
        else $error("header RAM read and write collide");

    // Carving only writes headers inside the page being carved.
    a_carve_in_page: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CARVE) |-> (ram_wr_en && ((ram_wr_addr >> PAGE_SHIFT) == GRAN_W'(page_reg))))
        else $error("carve write outside current page");

    // The initial carve happens once and is never undone.
    a_carve_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(carve_done_reg))
        else $error("initial carve flag dropped");

    // A result only appears out of a working state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result produced while idle");

    // An accepted request always leaves the idle state.
    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != S_IDLE))
        else $error("accepted request not started");

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the size-class free-list allocator: directed requests, then
// phased random traffic under several refill settings. Needs scfla_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;
    import scfla_pkg::*;

    localparam int IDLE_PCT    = 27;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 250;
    localparam int CALM_FROM   = 600;
    localparam int CALM_TO     = 760;
    localparam int TAIL_CYCLES = 2200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 50;
    localparam int FREED_KEEP  = 64;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [BYTES_W-1:0] bytes;
        status_t            status;
    } grant_t;

    typedef struct packed {
        op_t               op;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        grant_t            want;
    } request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = OP_ALLOC;
    logic [REQ_W-1:0]   request_bytes = '0;
    logic [ADDR_W-1:0]  block_address = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ADDR_W-1:0]  granted_address;
    logic [BYTES_W-1:0] granted_bytes;
    logic [1:0]         status;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;

    size_class_free_list_allocator_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .request_bytes   (request_bytes),
        .block_address   (block_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted_address (granted_address),
        .granted_bytes   (granted_bytes),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Allocator state as the testbench expects it to evolve.
    logic [WORD_W-1:0] free_head [NUM_CLASSES];
    logic [WORD_W-1:0] hdr_word [NUM_GRANULES];
    bit                hdr_written [NUM_GRANULES];
    int unsigned       pages_carved = 0;
    bit                pool_seeded = 1'b0;
    logic [CFG_W-1:0]  refill_setting = REFILL_RESET;

    request_t    pending_q [$];
    grant_t      grant_q [$];
    int unsigned live_q [$];
    int unsigned freed_q [$];
    request_t    offered;

    int  items_queued = 0;
    int  items_accepted = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  in_took = 1'b0;
    logic calm;

    assign calm = (items_accepted >= CALM_FROM) && (items_accepted < CALM_TO);

    initial
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            free_head[c] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
        begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    function automatic int unsigned fit_class(input int unsigned total);
        int unsigned c;
        c = 0;
        while (c + 1 < NUM_CLASSES && (MIN_CELL << c) < total)
        begin
            c++;
        end
        return c;
    endfunction

    function automatic int unsigned granule_of(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] base;
        base = addr - ADDR_W'(HEADER_BYTES);
        return int'(base >> MIN_SHIFT);
    endfunction

    // A fresh page becomes an ascending chain whose tail links to the old list head.
    function automatic void carve_page_into(input int unsigned cls);
        int unsigned size;
        int unsigned cells;
        int unsigned base;
        int unsigned g;
        int unsigned link;
        size = MIN_CELL << cls;
        cells = PAGE_BYTES / size;
        base = pages_carved * PAGE_BYTES;
        if (cells == 0)
        begin
            return;
        end
        for (int unsigned k = 0; k < cells; k++)
        begin
            g = (base + k * size) >> MIN_SHIFT;
            link = (k + 1 < cells) ? ((base + (k + 1) * size) >> MIN_SHIFT) + 1
                                   : int'(free_head[cls]);
            if (g < NUM_GRANULES)
            begin
                hdr_word[g] = WORD_W'(link);
                hdr_written[g] = 1'b1;
            end
        end
        free_head[cls] = WORD_W'((base >> MIN_SHIFT) + 1);
        pages_carved++;
    endfunction

    function automatic void seed_pool();
        for (int unsigned c = 0; c < NUM_CLASSES; c++)
        begin
            if (pages_carved < NUM_PAGES)
            begin
                carve_page_into(c);
            end
        end
        pool_seeded = 1'b1;
    endfunction

    // True when the request would read a header word that was never written.
    function automatic bit reads_unknown(input op_t kind, input logic [REQ_W-1:0] req,
                                         input logic [ADDR_W-1:0] addr);
        int unsigned total;
        int unsigned head;
        int unsigned g;
        if (!pool_seeded)
        begin
            seed_pool();
        end
        if (kind == OP_ALLOC)
        begin
            total = int'(req) + HEADER_BYTES;
            if (total > MAX_CLASS_BYTES)
            begin
                return 1'b0;
            end
            head = free_head[fit_class(total)];
            return head != 0 && head - 1 < NUM_GRANULES && !hdr_written[head - 1];
        end
        g = granule_of(addr);
        return g < NUM_GRANULES && !hdr_written[g];
    endfunction

    function automatic grant_t predict_grant(input op_t kind, input logic [REQ_W-1:0] req,
                                             input logic [ADDR_W-1:0] addr);
        grant_t r;
        int unsigned total;
        int unsigned cls;
        int unsigned head;
        int unsigned g;
        r.address = '0;
        r.bytes = '0;
        r.status = STATUS_OK;
        if (!pool_seeded)
        begin
            seed_pool();
        end
        if (kind == OP_ALLOC)
        begin
            total = int'(req) + HEADER_BYTES;
            if (total > MAX_CLASS_BYTES)
            begin
                r.status = STATUS_TOO_LARGE;
                return r;
            end
            cls = fit_class(total);
            if (free_head[cls] == 0)
            begin
                for (int unsigned i = 0; i < refill_setting && pages_carved < NUM_PAGES; i++)
                begin
                    carve_page_into(cls);
                end
            end
            head = free_head[cls];
            if (head != 0 && head - 1 >= NUM_GRANULES)
            begin
                free_head[cls] = '0;
                head = 0;
            end
            if (head == 0)
            begin
                r.status = STATUS_OOM;
                return r;
            end
            g = head - 1;
            free_head[cls] = hdr_word[g];
            hdr_word[g] = WORD_W'(MIN_CELL << cls);
            r.address = ADDR_W'((g << MIN_SHIFT) + HEADER_BYTES);
            r.bytes = BYTES_W'(MIN_CELL << cls);
        end
        else
        begin
            g = granule_of(addr);
            // Frees outside the pool or of a cell whose header exceeds the largest class size are dropped.
            if (g < NUM_GRANULES && hdr_word[g] <= MAX_CLASS_BYTES)
            begin
                cls = fit_class(hdr_word[g]);
                hdr_word[g] = free_head[cls];
                free_head[cls] = WORD_W'(g + 1);
            end
        end
        return r;
    endfunction

    task automatic offer_item(input op_t kind, input logic [REQ_W-1:0] req,
                              input logic [ADDR_W-1:0] addr);
        request_t it;
        if (reads_unknown(kind, req, addr))
        begin
            return;
        end
        it.op = kind;
        it.req = req;
        it.addr = addr;
        it.want = predict_grant(kind, req, addr);
        if (kind == OP_ALLOC && it.want.status == STATUS_OK)
        begin
            live_q.push_back(it.want.address);
        end
        if (kind == OP_FREE)
        begin
            freed_q.push_back(addr);
            if (freed_q.size() > FREED_KEEP)
            begin
                void'(freed_q.pop_front());
            end
        end
        pending_q.push_back(it);
        items_queued++;
    endtask

    // Any byte of the header granule identifies the cell, so the offset is random.
    task automatic free_live_at(input int idx);
        int unsigned a;
        a = live_q[idx];
        live_q.delete(idx);
        offer_item(OP_FREE, REQ_W'($urandom), ADDR_W'(a + $urandom_range(MIN_CELL - 1)));
    endtask

    task automatic alloc_random();
        int unsigned pick;
        int unsigned c;
        logic [REQ_W-1:0] req;
        pick = $urandom_range(99);
        c = $urandom_range(NUM_CLASSES - 1);
        if (pick < 8)
        begin
            req = REQ_W'($urandom);
        end
        else if (pick < 14)
        begin
            req = REQ_W'((MIN_CELL << c) - HEADER_BYTES + $urandom_range(1));
        end
        else if (c == 0)
        begin
            req = REQ_W'($urandom_range(MIN_CELL - HEADER_BYTES));
        end
        else
        begin
            req = REQ_W'($urandom_range((MIN_CELL << c) - HEADER_BYTES,
                                        (MIN_CELL << (c - 1)) + 1 - HEADER_BYTES));
        end
        offer_item(OP_ALLOC, req, ADDR_W'($urandom));
    endtask

    task automatic run_phase(input int count, input int alloc_pct);
        int start;
        int unsigned pick;
        int unsigned a;
        start = items_queued;
        while (items_queued - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < alloc_pct || live_q.size() == 0)
            begin
                alloc_random();
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 88)
                begin
                    free_live_at($urandom_range(live_q.size() - 1));
                end
                else if (pick < 95 && freed_q.size() != 0)
                begin
                    // Repeat frees mostly hit a header holding a far link and are dropped;
                    // now and then one relinks a list.
                    a = freed_q[$urandom_range(freed_q.size() - 1)];
                    if (hdr_word[granule_of(ADDR_W'(a))] > MAX_CLASS_BYTES ||
                        $urandom_range(7) == 0)
                    begin
                        offer_item(OP_FREE, REQ_W'($urandom), ADDR_W'(a));
                    end
                end
                else
                begin
                    offer_item(OP_FREE, REQ_W'($urandom), ADDR_W'($urandom));
                end
            end
        end
    endtask

    task automatic run_directed();
        int unsigned sizes [13];
        sizes = '{0, 24, 25, 56, 120, 248, 504, 1016, 2040, 2040, 2040, 2041, 65535};
        foreach (sizes[i])
        begin
            offer_item(OP_ALLOC, REQ_W'(sizes[i]), '0);
        end
        // Return a 2048-byte cell and a 32-byte cell; both come straight back.
        free_live_at(8);
        free_live_at(0);
        offer_item(OP_ALLOC, '0, '1);
        offer_item(OP_ALLOC, REQ_W'(2033), '1);
    endtask

    task automatic write_refill(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        refill_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || results_seen != items_queued)
        begin
            @(posedge clk);
        end
    endtask

    // Request driver.
    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            in_took = 1'b0;
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                offered = pending_q.pop_front();
                op <= offered.op;
                request_bytes <= offered.req;
                block_address <= offered.addr;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off so the block backs up into its input.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Monitor: records accepted requests and checks every result in order.
    always @(posedge clk)
    begin
        grant_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                grant_q.push_back(offered.want);
                items_accepted++;
                in_took = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (grant_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = grant_q.pop_front();
                    results_seen++;
                    if (granted_address !== want.address)
                    begin
                        report_mismatch($sformatf("granted_address %0h, expected %0h",
                                                  granted_address, want.address));
                    end
                    if (granted_bytes !== want.bytes)
                    begin
                        report_mismatch($sformatf("granted_bytes %0d, expected %0d",
                                                  granted_bytes, want.bytes));
                    end
                    if (status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_refill(CFG_W'(1));
        run_directed();
        wait_drained();
        // A refill of zero pages turns every empty list into out-of-memory.
        write_refill(CFG_W'(0));
        run_phase(120, 70);
        wait_drained();
        write_refill(CFG_W'(8));
        run_phase(330, 65);
        wait_drained();
        write_refill(CFG_W'(15));
        run_phase(230, 60);
        wait_drained();
        write_refill(REFILL_RESET);
        run_phase(230, 55);
        wait_drained();
        write_refill(CFG_W'(1));
        run_phase(240, 50);
        wait_drained();

        // Long enough for the biggest refill to finish, so a stray late result is caught.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (grant_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", grant_q.size()));
        end
        if (mismatches == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
rtl/scfla_pkg.sv
rtl/scfla_ram.sv
rtl/size_class_free_list_allocator_unit.sv
test/tb.sv
